// File: rtl/core/rc4_pkg.sv
// Shared types, constants and command codes for the RC4 stream cipher.
`default_nettype none

package rc4_pkg;

  localparam int KEY_STORE_DEPTH = 256;
  localparam int PERM_SIZE       = 256;
  localparam int PERM_AW         = $clog2(PERM_SIZE);
  localparam int LEN_W           = 9;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_SCHED = 2'd1;
  localparam logic [1:0] ACT_DATA  = 2'd2;

  localparam logic KIND_SCHED = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] key_index;
    logic [7:0] key_byte;
    logic [7:0] data_in;
  } item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       result_kind;
  } result_t;

  typedef enum logic [3:0] {
    S_INIT_FILL,
    S_IDLE,
    S_FILL,
    S_KSA_RD,
    S_KSA_MIX,
    S_KSA_WR1,
    S_KSA_WR2,
    S_SCHED_OUT,
    S_PRGA_J,
    S_PRGA_T,
    S_PRGA_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_KEY_LOAD,
    OP_FILL,
    OP_KSA_RD,
    OP_KSA_MIX,
    OP_KSA_WR1,
    OP_KSA_WR2,
    OP_SCHED_OUT,
    OP_PRGA_I,
    OP_PRGA_J,
    OP_PRGA_T,
    OP_PRGA_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/rc4_stream_cipher.sv
// Top level of the RC4 stream cipher: controller plus datapath.
`default_nettype none

// channel  | handshake                 | payload
// ---------+---------------------------+-------------------------------
// config   | cfg_we                    | cfg_wdata (key_length, 9 bit)
// item     | item_valid / item_ready   | item (action, key, data)
// result   | result_valid / result_ready | result (data_out, result_kind)
//
// After reset a pass loads the identity permutation into all 256 entries; item_ready stays low meanwhile.
// Key load: taken in the idle state. Data byte: PRGA_I (from idle), PRGA_J, PRGA_T and PRGA_OUT, set by the
// dependent S[i], S[j], S[t] reads and swap writes on the one-read permutation RAM.
// Key schedule: accept, fill of 256 entries, KSA_RD/KSA_MIX/KSA_WR1/KSA_WR2 per permutation entry, done beat.
// A full output register stalls only the final step; a new item is taken while a result waits.

module rc4_stream_cipher #(
  parameter int KEY_STORE_DEPTH = rc4_pkg::KEY_STORE_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [rc4_pkg::LEN_W-1:0] cfg_wdata,
  input  wire logic                      item_valid,
  output logic                           item_ready,
  input  wire rc4_pkg::item_t            item,
  output logic                           result_valid,
  input  wire logic                      result_ready,
  output rc4_pkg::result_t               result
);

  rc4_pkg::dp_cmd_t cmd;
  rc4_pkg::dp_sts_t sts;

  rc4_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_action (item.action),
    .item_ready  (item_ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  rc4_dp #(.KEY_STORE_DEPTH(KEY_STORE_DEPTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

`default_nettype wire

// File: rtl/core/rc4_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/rc4_dp.sv
// Datapath: permutation and key stores, indices, key schedule and keystream arithmetic.
`default_nettype none

module rc4_dp #(
  parameter int KEY_STORE_DEPTH = rc4_pkg::KEY_STORE_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [rc4_pkg::LEN_W-1:0] cfg_wdata,
  input  wire rc4_pkg::item_t           item,
  output rc4_pkg::result_t              result,
  output logic                          result_valid,
  input  wire logic                     result_ready,
  input  wire rc4_pkg::dp_cmd_t         cmd,
  output rc4_pkg::dp_sts_t              sts
);

  localparam int KW = $clog2(KEY_STORE_DEPTH);
  localparam int AW = rc4_pkg::PERM_AW;
  localparam int LW = rc4_pkg::LEN_W;
  localparam logic [LW-1:0] DEPTH_LEN = LW'(KEY_STORE_DEPTH);

  logic [LW-1:0] key_length;
  logic [LW-1:0] eff_len;
  logic [AW-1:0] cnt;
  logic [KW-1:0] pos;
  logic [LW-1:0] pos_inc;
  logic          pos_last;
  logic [7:0]    acc;
  logic [7:0]    acc_sum;
  logic [7:0]    idx_i;
  logic [7:0]    idx_j;
  logic [7:0]    i_inc;
  logic [7:0]    j_sum;
  logic [7:0]    t_sum;
  logic [7:0]    si;
  logic [7:0]    sj;
  logic [7:0]    t_addr;
  logic          hit_i;
  logic          hit_j;
  logic [7:0]    din;
  logic [7:0]    ks;
  logic          out_free;
  logic          out_load;

  logic          p_we;
  logic [AW-1:0] p_waddr;
  logic [7:0]    p_wdata;
  logic [AW-1:0] p_raddr;
  logic [7:0]    p_rdata;
  logic          k_we;
  logic [KW-1:0] k_waddr;
  logic [7:0]    k_wdata;
  logic [KW-1:0] k_raddr;
  logic [7:0]    k_rdata;

  rc4_ram #(.WIDTH(8), .DEPTH(rc4_pkg::PERM_SIZE)) u_perm (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  rc4_ram #(.WIDTH(8), .DEPTH(KEY_STORE_DEPTH)) u_key (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  always_comb begin
    if (key_length == '0) begin
      eff_len = LW'(1);
    end else if (key_length > DEPTH_LEN) begin
      eff_len = DEPTH_LEN;
    end else begin
      eff_len = key_length;
    end
  end

  assign pos_inc  = LW'(pos) + LW'(1);
  assign pos_last = (pos_inc >= eff_len);
  assign acc_sum  = acc + p_rdata + k_rdata;
  assign i_inc    = idx_i + 8'd1;
  assign j_sum    = idx_j + p_rdata;
  assign t_sum    = si + p_rdata;
  // S[j] is written last, so it wins when t lands on both indices
  assign ks       = hit_j ? si : (hit_i ? sj : p_rdata);
  assign out_free = !result_valid || result_ready;
  assign out_load = out_free &&
                    (cmd.op == rc4_pkg::OP_PRGA_OUT || cmd.op == rc4_pkg::OP_SCHED_OUT);

  assign sts.cnt_last = (cnt == {AW{1'b1}});
  assign sts.out_free = out_free;

  always_comb begin
    p_we    = 1'b0;
    p_waddr = cnt;
    p_wdata = 8'(cnt);
    p_raddr = cnt;
    k_we    = 1'b0;
    k_waddr = item.key_index[KW-1:0];
    k_wdata = item.key_byte;
    k_raddr = pos;
    unique case (cmd.op) inside
      rc4_pkg::OP_KEY_LOAD: begin
        k_we = (LW'(item.key_index) < DEPTH_LEN);
      end
      rc4_pkg::OP_FILL: begin
        p_we = 1'b1;
      end
      rc4_pkg::OP_KSA_MIX: begin
        p_raddr = acc_sum;
      end
      rc4_pkg::OP_KSA_WR1: begin
        p_we    = 1'b1;
        p_wdata = p_rdata;
      end
      rc4_pkg::OP_KSA_WR2: begin
        p_we    = 1'b1;
        p_waddr = acc;
        p_wdata = si;
      end
      rc4_pkg::OP_PRGA_I: begin
        p_raddr = i_inc;
      end
      rc4_pkg::OP_PRGA_J: begin
        p_raddr = j_sum;
      end
      rc4_pkg::OP_PRGA_T: begin
        p_we    = 1'b1;
        p_waddr = idx_i;
        p_wdata = p_rdata;
        p_raddr = t_sum;
      end
      rc4_pkg::OP_PRGA_OUT: begin
        p_we    = 1'b1;
        p_waddr = idx_j;
        p_wdata = si;
        p_raddr = t_addr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length   <= LW'(1);
      cnt          <= '0;
      idx_i        <= '0;
      idx_j        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        key_length <= cfg_wdata;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (cmd.op) inside
        rc4_pkg::OP_IDLE, rc4_pkg::OP_KEY_LOAD: cnt <= '0;
        rc4_pkg::OP_FILL, rc4_pkg::OP_KSA_WR2:  cnt <= cnt + AW'(1);
        rc4_pkg::OP_SCHED_OUT: begin
          idx_i <= '0;
          idx_j <= '0;
        end
        rc4_pkg::OP_PRGA_I: idx_i <= i_inc;
        rc4_pkg::OP_PRGA_J: idx_j <= j_sum;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op) inside
      rc4_pkg::OP_IDLE, rc4_pkg::OP_KEY_LOAD: begin
        acc <= '0;
        pos <= '0;
        din <= item.data_in;
      end
      rc4_pkg::OP_KSA_MIX: begin
        si  <= p_rdata;
        acc <= acc_sum;
      end
      rc4_pkg::OP_KSA_WR2: begin
        pos <= pos_last ? '0 : pos_inc[KW-1:0];
      end
      rc4_pkg::OP_PRGA_I: begin
        din <= item.data_in;
      end
      rc4_pkg::OP_PRGA_J: begin
        si <= p_rdata;
      end
      rc4_pkg::OP_PRGA_T: begin
        sj     <= p_rdata;
        t_addr <= t_sum;
        hit_i  <= (t_sum == idx_i);
        hit_j  <= (t_sum == idx_j);
      end
      default: begin
      end
    endcase
    if (out_load) begin
      if (cmd.op == rc4_pkg::OP_PRGA_OUT) begin
        result.data_out    <= din ^ ks;
        result.result_kind <= rc4_pkg::KIND_DATA;
      end else begin
        result.data_out    <= '0;
        result.result_kind <= rc4_pkg::KIND_SCHED;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rc4_ctrl.sv
// Controller: sequences reset fill, key schedule and per-byte keystream steps.
`default_nettype none

module rc4_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire logic [1:0]       item_action,
  output logic                  item_ready,
  output rc4_pkg::dp_cmd_t      cmd,
  input  wire rc4_pkg::dp_sts_t sts
);

  rc4_pkg::state_t state;
  rc4_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rc4_pkg::S_INIT_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = rc4_pkg::OP_IDLE;
    item_ready = 1'b0;
    unique case (state)
      rc4_pkg::S_INIT_FILL: begin
        cmd.op = rc4_pkg::OP_FILL;
        if (sts.cnt_last) state_next = rc4_pkg::S_IDLE;
      end
      rc4_pkg::S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          unique case (item_action)
            rc4_pkg::ACT_LOAD:  cmd.op = rc4_pkg::OP_KEY_LOAD;
            rc4_pkg::ACT_SCHED: state_next = rc4_pkg::S_FILL;
            rc4_pkg::ACT_DATA: begin
              cmd.op     = rc4_pkg::OP_PRGA_I;
              state_next = rc4_pkg::S_PRGA_J;
            end
            default: begin
            end
          endcase
        end
      end
      rc4_pkg::S_FILL: begin
        cmd.op = rc4_pkg::OP_FILL;
        if (sts.cnt_last) state_next = rc4_pkg::S_KSA_RD;
      end
      rc4_pkg::S_KSA_RD: begin
        cmd.op     = rc4_pkg::OP_KSA_RD;
        state_next = rc4_pkg::S_KSA_MIX;
      end
      rc4_pkg::S_KSA_MIX: begin
        cmd.op     = rc4_pkg::OP_KSA_MIX;
        state_next = rc4_pkg::S_KSA_WR1;
      end
      rc4_pkg::S_KSA_WR1: begin
        cmd.op     = rc4_pkg::OP_KSA_WR1;
        state_next = rc4_pkg::S_KSA_WR2;
      end
      rc4_pkg::S_KSA_WR2: begin
        cmd.op     = rc4_pkg::OP_KSA_WR2;
        state_next = sts.cnt_last ? rc4_pkg::S_SCHED_OUT : rc4_pkg::S_KSA_RD;
      end
      rc4_pkg::S_SCHED_OUT: begin
        cmd.op = rc4_pkg::OP_SCHED_OUT;
        if (sts.out_free) state_next = rc4_pkg::S_IDLE;
      end
      rc4_pkg::S_PRGA_J: begin
        cmd.op     = rc4_pkg::OP_PRGA_J;
        state_next = rc4_pkg::S_PRGA_T;
      end
      rc4_pkg::S_PRGA_T: begin
        cmd.op     = rc4_pkg::OP_PRGA_T;
        state_next = rc4_pkg::S_PRGA_OUT;
      end
      rc4_pkg::S_PRGA_OUT: begin
        // holding here rewrites S[j] with the same value
        cmd.op = rc4_pkg::OP_PRGA_OUT;
        if (sts.out_free) state_next = rc4_pkg::S_IDLE;
      end
      default: begin
        state_next = rc4_pkg::S_IDLE;
      end
    endcase
  end

  a_data_start: assert property (@(posedge clk) disable iff (rst)
    (state == rc4_pkg::S_IDLE && item_valid && item_action == rc4_pkg::ACT_DATA)
    |=> state == rc4_pkg::S_PRGA_J)
    else $error("data beat did not start keystream step");

  a_prga_order: assert property (@(posedge clk) disable iff (rst)
    (state == rc4_pkg::S_PRGA_J) |=> state == rc4_pkg::S_PRGA_T ##1 state == rc4_pkg::S_PRGA_OUT)
    else $error("keystream step out of order");

  a_ksa_loop: assert property (@(posedge clk) disable iff (rst)
    (state == rc4_pkg::S_KSA_WR2 && !sts.cnt_last) |=> state == rc4_pkg::S_KSA_RD)
    else $error("key schedule left its loop early");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    ((state == rc4_pkg::S_PRGA_OUT || state == rc4_pkg::S_SCHED_OUT) && !sts.out_free)
    |=> $stable(state))
    else $error("result dropped while output register full");

endmodule

`default_nettype wire

// File: bench/rc4_stream_cipher_test.sv
// Self-checking bench for rc4_stream_cipher: directed table, then keyed random traffic.
module rc4_stream_cipher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rc4_pkg::*;

  localparam logic [1:0] ACT_NOP = 2'd3;  // unused code, dropped by the block

  localparam int ITEM_GOAL   = 1650;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;
  localparam int TAIL        = 40;
  localparam int STALL_LIMIT = 8000;

  typedef struct packed {
    item_t   beat;
    logic    typed;
    result_t want;
  } row_t;

  // Right after reset the permutation is the identity, so the first keystream
  // bytes are 02, 05, 07.
  localparam int N_ROWS = 20;
  localparam row_t DIRECTED [0:N_ROWS-1] = '{
    // action    index  kbyte  data   typed  data_out  kind
    {ACT_DATA,  8'h00, 8'h00, 8'h00, 1'b1, 8'h02, KIND_DATA},
    {ACT_DATA,  8'h00, 8'h00, 8'hFF, 1'b1, 8'hFA, KIND_DATA},
    {ACT_DATA,  8'h00, 8'h00, 8'h80, 1'b1, 8'h87, KIND_DATA},
    {ACT_NOP,   8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, KIND_SCHED},
    {ACT_LOAD,  8'h00, 8'hFF, 8'h00, 1'b0, 8'h00, KIND_SCHED},
    {ACT_LOAD,  8'hFF, 8'h00, 8'hFF, 1'b0, 8'h00, KIND_SCHED},
    {ACT_LOAD,  8'h01, 8'h5A, 8'hA5, 1'b0, 8'h00, KIND_SCHED},
    {ACT_SCHED, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, KIND_SCHED},
    {ACT_DATA,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00, KIND_DATA},
    {ACT_DATA,  8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, KIND_DATA},
    {ACT_DATA,  8'h00, 8'h00, 8'hA5, 1'b0, 8'h00, KIND_DATA},
    {ACT_LOAD,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00, KIND_SCHED},
    {ACT_SCHED, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h00, KIND_SCHED},
    {ACT_DATA,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00, KIND_DATA},
    {ACT_DATA,  8'h00, 8'h00, 8'h01, 1'b0, 8'h00, KIND_DATA},
    {ACT_NOP,   8'h00, 8'h00, 8'h00, 1'b0, 8'h00, KIND_SCHED},
    {ACT_DATA,  8'h00, 8'h00, 8'hFF, 1'b0, 8'h00, KIND_DATA},
    {ACT_LOAD,  8'h80, 8'h7F, 8'h00, 1'b0, 8'h00, KIND_SCHED},
    {ACT_LOAD,  8'h7F, 8'h80, 8'h00, 1'b0, 8'h00, KIND_SCHED},
    {ACT_DATA,  8'h00, 8'h00, 8'h3C, 1'b0, 8'h00, KIND_DATA}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;
  logic             item_valid = 1'b0;
  logic             item_ready;
  item_t            item = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  result_t          result;

  // cipher state as the bench sees it
  logic [7:0]       sbox [0:PERM_SIZE-1];
  logic [7:0]       key_mem [0:KEY_STORE_DEPTH-1];
  bit               key_written [0:KEY_STORE_DEPTH-1];
  logic [7:0]       ptr_i = '0;
  logic [7:0]       ptr_j = '0;
  logic [LEN_W-1:0] key_len = LEN_W'(1);
  result_t          cipher_q [$];

  bit tx_steady   = 1'b0;
  bit rx_steady   = 1'b0;
  bit rx_hold_req = 1'b0;
  int beats_sent  = 0;
  int schedules   = 0;
  int settings    = 0;
  int results_in  = 0;
  int holds       = 0;
  int errors      = 0;
  int idle_cycles = 0;

  rc4_stream_cipher uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int key_span(input logic [LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > KEY_STORE_DEPTH) return KEY_STORE_DEPTH;
    return int'(len);
  endfunction

  task automatic cipher_step(input item_t beat, output bit yields, output result_t res);
    int         span;
    int         pos;
    logic [7:0] acc;
    logic [7:0] tmp;
    logic [7:0] t;
    yields = 1'b0;
    res    = '0;
    case (beat.action)
      ACT_LOAD: begin
        if (beat.key_index < KEY_STORE_DEPTH) begin
          key_mem[beat.key_index]     = beat.key_byte;
          key_written[beat.key_index] = 1'b1;
        end
      end
      ACT_SCHED: begin
        span = key_span(key_len);
        for (int n = 0; n < PERM_SIZE; n++) sbox[n] = 8'(n);
        acc = '0;
        pos = 0;
        for (int n = 0; n < PERM_SIZE; n++) begin
          acc       = acc + sbox[n] + key_mem[pos];
          tmp       = sbox[n];
          sbox[n]   = sbox[acc];
          sbox[acc] = tmp;
          pos++;
          if (pos >= span) pos = 0;
        end
        ptr_i  = '0;
        ptr_j  = '0;
        yields = 1'b1;
        res    = {8'h00, KIND_SCHED};
      end
      ACT_DATA: begin
        ptr_i       = ptr_i + 8'd1;
        ptr_j       = ptr_j + sbox[ptr_i];
        tmp         = sbox[ptr_i];
        sbox[ptr_i] = sbox[ptr_j];
        sbox[ptr_j] = tmp;
        t           = sbox[ptr_i] + sbox[ptr_j];
        yields      = 1'b1;
        res         = {beat.data_in ^ sbox[t], KIND_DATA};
      end
      default: ;
    endcase
  endtask

  // Offer one beat; on acceptance run the cipher model and queue what comes back.
  task automatic send_beat(input item_t beat, input logic typed, input result_t want);
    int      gap;
    bit      yields;
    result_t res;
    gap = tx_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= beat;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    cipher_step(beat, yields, res);
    if (typed) res = want;
    if (yields) cipher_q = {cipher_q, res};
    if (beat.action != ACT_NOP) beats_sent++;
    if (beat.action == ACT_SCHED) schedules++;
  endtask

  task automatic send_op(input logic [1:0] act, input logic [7:0] idx);
    item_t beat;
    beat.action    = act;
    beat.key_index = idx;
    beat.key_byte  = 8'($urandom);
    beat.data_in   = 8'($urandom);
    send_beat(beat, 1'b0, '0);
  endtask

  // Every key byte the schedule will read gets written first; some are refreshed.
  task automatic keyed_schedule(input int span);
    for (int k = 0; k < span; k++)
      if (!key_written[k] || $urandom_range(0, 7) == 0) send_op(ACT_LOAD, 8'(k));
    send_op(ACT_SCHED, 8'($urandom));
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    // loads and dropped beats give nothing back, let them retire
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_key_length(input logic [LEN_W-1:0] len);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
    key_len   = len;
    settings++;
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] len, input bit hold);
    int span;
    int n_seq;
    int burst;
    int pick;
    set_key_length(len);
    span      = key_span(len);
    tx_steady = hold || ($urandom_range(0, 3) == 0);
    n_seq     = $urandom_range(1, 3);
    for (int s = 0; s < n_seq; s++) begin
      if ($urandom_range(0, 3) == 0) send_op(ACT_NOP, 8'($urandom));
      keyed_schedule(span);
      if (hold && s == 0) rx_hold_req = 1'b1;
      burst = (hold && s == 0) ? 40 : $urandom_range(4, 40);
      for (int b = 0; b < burst; b++) begin
        pick = $urandom_range(0, 23);
        if (pick == 0) send_op(ACT_NOP, 8'($urandom));
        else if (pick == 1) send_op(ACT_LOAD, 8'($urandom));
        else if (pick == 2) keyed_schedule(span);
        else send_op(ACT_DATA, 8'($urandom));
      end
    end
  endtask

  task automatic flag(input string what, input logic [7:0] want_v, input logic [7:0] got_v);
    errors++;
    $display("%0t ns: %s mismatch: expected %02h, got %02h", $time, what, want_v, got_v);
  endtask

  initial begin : stimulus
    logic [LEN_W-1:0] len;
    int               phase;
    for (int n = 0; n < PERM_SIZE; n++) sbox[n] = 8'(n);
    for (int n = 0; n < KEY_STORE_DEPTH; n++) begin
      key_mem[n]     = '0;
      key_written[n] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_ROWS; r++)
      send_beat(DIRECTED[r].beat, DIRECTED[r].typed, DIRECTED[r].want);

    phase = 0;
    while (beats_sent < ITEM_GOAL) begin
      case (phase)
        0:       len = '0;
        1:       len = '1;
        2:       len = LEN_W'(1);
        3:       len = LEN_W'(256);
        4:       len = LEN_W'(257);
        default: len = ($urandom_range(0, 3) != 0) ? LEN_W'($urandom_range(1, 16))
                                                   : LEN_W'($urandom);
      endcase
      run_phase(len, phase == 3 || $urandom_range(0, 11) == 0);
      phase++;
    end

    drain();
    repeat (TAIL) @(posedge clk);
    $display("Run: %0d beats incl. %0d key schedules over %0d key length settings,",
             beats_sent, schedules, settings);
    $display("     %0d results checked, %0d long output back-pressure spells, %0d mismatches",
             results_in, holds, errors);
    if (errors == 0) begin
      $display("rc4_stream_cipher verification clean");
    end else begin
      $display("rc4_stream_cipher verification failed");
    end
    $finish;
  end

  initial begin : result_checker
    int      stall;
    int      taken;
    result_t want;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        stall       = HOLD_CYCLES;
        rx_hold_req = 1'b0;
        holds++;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      results_in++;
      if (cipher_q.size() == 0) begin
        flag("unexpected beat, data_out", 8'hxx, result.data_out);
      end else begin
        want = cipher_q.pop_front();
        if (result.data_out !== want.data_out)
          flag("data_out", want.data_out, result.data_out);
        if (result.result_kind !== want.result_kind)
          flag("result_kind", {7'd0, want.result_kind}, {7'd0, result.result_kind});
      end
      taken++;
      if (taken % 40 == 0) rx_steady = ($urandom_range(0, 3) == 0);
    end
  end

  // watchdog: no handshake on either channel for too long
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("rc4_stream_cipher verification failed");
        $finish;
      end
    end
  end

endmodule

// File: sim.f
rtl/core/rc4_pkg.sv
rtl/core/rc4_ram.sv
rtl/core/rc4_dp.sv
rtl/core/rc4_ctrl.sv
rtl/core/rc4_stream_cipher.sv
bench/rc4_stream_cipher_test.sv
